[hw/rtl/asp16_pkg.sv]
// Shared types and constants for the stereo PCM16 sample converter.
package asp16_pkg;

   // Register indexes on the control port (byte address / 4)
   localparam logic [1:0] REG_SAMPLE_FORMAT   = 2'd0;
   localparam logic [1:0] REG_CONTAINER_BYTES = 2'd1;
   localparam logic [1:0] REG_STEREO_INPUT    = 2'd2;

   // Sample format codes
   localparam logic FMT_INTEGER = 1'b0;
   localparam logic FMT_FLOAT   = 1'b1;

   // Container sizes in bytes
   localparam logic [3:0] BYTES_1 = 4'd1;
   localparam logic [3:0] BYTES_2 = 4'd2;
   localparam logic [3:0] BYTES_3 = 4'd3;
   localparam logic [3:0] BYTES_4 = 4'd4;
   localparam logic [3:0] BYTES_8 = 4'd8;

   // Reset values of the registers
   localparam logic       RESET_SAMPLE_FORMAT   = FMT_INTEGER;
   localparam logic [3:0] RESET_CONTAINER_BYTES = BYTES_2;
   localparam logic       RESET_STEREO_INPUT    = 1'b1;

   // Largest right shift of m * 32767 that decode passes on; larger shifts give zero
   localparam int         SHIFT_MAX  = 68;
   localparam int         MANT_W     = 53;
   localparam int         PROD_W     = MANT_W + 15;
   localparam logic [14:0] FULL_SCALE = 15'h7FFF;

   typedef struct packed {
      logic [63:0] left_raw;
      logic [63:0] right_raw;
      logic        last_in_packet;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_pcm;
      logic signed [15:0] right_pcm;
      logic               last_out;
   } rsp_type;

   typedef struct packed {
      logic       sample_format;
      logic [3:0] container_bytes;
      logic       stereo_input;
   } cfg_type;

   typedef struct packed {
      logic neg;    // result is negated
      logic zero;   // result forced to zero
      logic sat;    // result forced to full scale
   } flag_type;

   typedef struct packed {
      flag_type            flags;
      logic [MANT_W-1:0]   mant;    // magnitude before scaling
      logic [6:0]          shift;   // right shift of mant * 32767, before rounding
   } dec_type;

endpackage

[hw/rtl/asp16_csr.sv]
// Control and status registers of the PCM16 converter on an APB-style port.
module asp16_csr
   import asp16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic       sample_format_ff, sample_format_in;
   logic [3:0] container_bytes_ff, container_bytes_in;
   logic       stereo_input_ff, stereo_input_in;
   logic       wr_en;
   logic [1:0] reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      sample_format_in   = sample_format_ff;
      container_bytes_in = container_bytes_ff;
      stereo_input_in    = stereo_input_ff;
      if (wr_en) begin
         case (reg_index)
            REG_SAMPLE_FORMAT:   sample_format_in   = pwdata[0];
            REG_CONTAINER_BYTES: container_bytes_in = pwdata[3:0];
            REG_STEREO_INPUT:    stereo_input_in    = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff   <= RESET_SAMPLE_FORMAT;
         container_bytes_ff <= RESET_CONTAINER_BYTES;
         stereo_input_ff    <= RESET_STEREO_INPUT;
      end else begin
         sample_format_ff   <= sample_format_in;
         container_bytes_ff <= container_bytes_in;
         stereo_input_ff    <= stereo_input_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_SAMPLE_FORMAT:   prdata = {31'd0, sample_format_ff};
         REG_CONTAINER_BYTES: prdata = {28'd0, container_bytes_ff};
         REG_STEREO_INPUT:    prdata = {31'd0, stereo_input_ff};
         default:             prdata = 32'd0;
      endcase
   end

   assign cfg.sample_format   = sample_format_ff;
   assign cfg.container_bytes = container_bytes_ff;
   assign cfg.stereo_input    = stereo_input_ff;

endmodule

[hw/rtl/asp16_decode.sv]
// Pipeline stage 1: unpack one raw sample into sign, magnitude and shift.
module asp16_decode
   import asp16_pkg::*;
(
   input  logic        clock,
   input  logic [63:0] raw,
   input  cfg_type     cfg,
   output dec_type     dec_ff
);

   dec_type     dec_in;
   logic [7:0]  e32;
   logic [22:0] f32;
   logic [7:0]  t32;
   logic [10:0] e64;
   logic [51:0] f64;
   logic [10:0] t64;
   logic [32:0] ival;
   logic [32:0] imag;

   assign e32 = raw[30:23];
   assign f32 = raw[22:0];
   assign t32 = 8'd149 - e32;
   assign e64 = raw[62:52];
   assign f64 = raw[51:0];
   assign t64 = 11'd1074 - e64;

   // sign-extend the integer container to 33 bits, then take its magnitude
   always_comb begin
      case (cfg.container_bytes)
         BYTES_2: ival = {{17{raw[15]}}, raw[15:0]};
         BYTES_3: ival = {{9{raw[23]}}, raw[23:0]};
         default: ival = {raw[31], raw[31:0]};
      endcase
      imag = ival[32] ? (~ival + 33'd1) : ival;
   end

   always_comb begin
      dec_in            = '0;
      dec_in.flags.zero = 1'b1;
      if (cfg.sample_format == FMT_FLOAT) begin
         case (cfg.container_bytes)
            BYTES_4: begin
               dec_in.flags.neg = raw[31];
               if (e32 == 8'hFF && f32 != '0) begin
                  dec_in.flags.zero = 1'b1;
               end else if (e32 >= 8'd127) begin
                  dec_in.flags.zero = 1'b0;
                  dec_in.flags.sat  = 1'b1;
               end else if (e32 != '0 && t32 <= 8'(SHIFT_MAX)) begin
                  dec_in.flags.zero = 1'b0;
                  dec_in.mant       = {29'd0, 1'b1, f32};
                  dec_in.shift      = t32[6:0];
               end
            end
            BYTES_8: begin
               dec_in.flags.neg = raw[63];
               if (e64 == 11'h7FF && f64 != '0) begin
                  dec_in.flags.zero = 1'b1;
               end else if (e64 >= 11'd1023) begin
                  dec_in.flags.zero = 1'b0;
                  dec_in.flags.sat  = 1'b1;
               end else if (e64 != '0 && t64 <= 11'(SHIFT_MAX)) begin
                  dec_in.flags.zero = 1'b0;
                  dec_in.mant       = {1'b1, f64};
                  dec_in.shift      = t64[6:0];
               end
            end
            default: ;
         endcase
      end else begin
         case (cfg.container_bytes)
            BYTES_1: begin
               // offset binary around 128
               dec_in.flags.zero = 1'b0;
               dec_in.flags.neg  = ~raw[7];
               dec_in.mant       = raw[7] ? {46'd0, raw[6:0]}
                                          : MANT_W'(9'd128 - {1'b0, raw[7:0]});
               dec_in.shift      = 7'd6;
            end
            BYTES_2, BYTES_3, BYTES_4: begin
               dec_in.flags.zero = 1'b0;
               dec_in.flags.neg  = ival[32];
               dec_in.mant       = {20'd0, imag};
               case (cfg.container_bytes)
                  BYTES_2: dec_in.shift = 7'd14;
                  BYTES_3: dec_in.shift = 7'd22;
                  default: dec_in.shift = 7'd30;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
   end

endmodule

[hw/rtl/asp16_scale.sv]
// Pipeline stages 2 and 3: scale by 32767, shift, then round and sign.
module asp16_scale
   import asp16_pkg::*;
(
   input  logic               clock,
   input  dec_type            dec,
   output logic signed [15:0] pcm
);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [6:0]        shift_ff;
   flag_type          flags2_ff, flags3_ff;
   logic [PROD_W-1:0] shifted;
   logic [16:0]       quot_ff, quot_in;
   logic [17:0]       rsum;
   logic [16:0]       rounded;
   logic [14:0]       mag;
   logic [15:0]       mag16;

   // 32767 * m as (m << 15) - m
   assign prod_in = {dec.mant, 15'd0} - {15'd0, dec.mant};

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      shift_ff  <= dec.shift;
      flags2_ff <= dec.flags;
   end

   assign shifted = prod_ff >> shift_ff;
   assign quot_in = shifted[16:0];

   always_ff @(posedge clock) begin
      quot_ff   <= quot_in;
      flags3_ff <= flags2_ff;
   end

   // round half away from zero on the magnitude, then clamp
   assign rsum    = {1'b0, quot_ff} + 18'd1;
   assign rounded = rsum[17:1];

   always_comb begin
      if (flags3_ff.sat || rounded > {2'b00, FULL_SCALE}) begin
         mag = FULL_SCALE;
      end else begin
         mag = rounded[14:0];
      end
      mag16 = {1'b0, mag};
      if (flags3_ff.zero) begin
         pcm = '0;
      end else if (flags3_ff.neg) begin
         pcm = $signed(~mag16 + 16'd1);
      end else begin
         pcm = $signed(mag16);
      end
   end

endmodule

[hw/rtl/audio_sample_to_stereo_pcm16.sv]
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Four register stages: decode, multiply by 32767, shift, round/sign into the output register.
// Reset (synchronous, active high) clears the valid bits and loads the registers
// with integer format, 2 bytes per sample, stereo input; payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module audio_sample_to_stereo_pcm16
   import asp16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   // result channel
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   // control port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type            cfg;
   logic               accept;
   logic [63:0]        right_sel;
   dec_type            dec_left, dec_right;
   logic signed [15:0] pcm_left, pcm_right;

   // valid and last flag travel alongside the data through each stage
   logic [2:0] valid_ff, valid_in;
   logic [2:0] last_ff, last_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;

   // the pipeline advances every cycle, so never hold off a request
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   asp16_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // mono input: feed the left sample down the right lane as well
   assign right_sel = cfg.stereo_input ? req_data.right_raw : req_data.left_raw;

   asp16_decode u_dec_left (
      .clock  (clock),
      .raw    (req_data.left_raw),
      .cfg    (cfg),
      .dec_ff (dec_left)
   );

   asp16_decode u_dec_right (
      .clock  (clock),
      .raw    (right_sel),
      .cfg    (cfg),
      .dec_ff (dec_right)
   );

   asp16_scale u_scale_left (
      .clock (clock),
      .dec   (dec_left),
      .pcm   (pcm_left)
   );

   asp16_scale u_scale_right (
      .clock (clock),
      .dec   (dec_right),
      .pcm   (pcm_right)
   );

   // advance the valid and last flags one stage per cycle
   assign valid_in = {valid_ff[1:0], accept};
   assign last_in  = {last_ff[1:0], req_data.last_in_packet};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      rsp_data_in.left_pcm  = pcm_left;
      rsp_data_in.right_pcm = pcm_right;
      rsp_data_in.last_out  = last_ff[2];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every result stems from an earlier accepted request
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("result without a matching request");

   // the most negative code is never produced
   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.left_pcm != 16'sh8000 && rsp_data.right_pcm != 16'sh8000))
      else $error("result holds -32768");

   // mono input gives identical channels
   a_mono_copy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !cfg.stereo_input) |-> (rsp_data.right_pcm == rsp_data.left_pcm))
      else $error("mono result differs between channels");

   // last flag of the request reaches the result unchanged
   a_last_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_out == $past(req_data.last_in_packet, 4)))
      else $error("last flag lost");

endmodule

[sim/tb_audio_sample_to_stereo_pcm16.sv]
// Self-checking testbench for the stereo PCM16 sample converter.
module tb_audio_sample_to_stereo_pcm16
   import asp16_pkg::*;
();

   // Index past the end of the register map: writes there must change nothing
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int unsigned CORNER_COUNT = 25;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   audio_sample_to_stereo_pcm16 dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 8-unit period: high then low
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Frames waiting to be offered, and the stereo pairs the converter owes us
   req_type     frame_backlog[$];
   rsp_type     pcm_expected[$];
   // Shadow of the converter's registers, updated as each write lands
   cfg_type     model_cfg = '{RESET_SAMPLE_FORMAT, RESET_CONTAINER_BYTES, RESET_STEREO_INPUT};

   int unsigned frames_queued   = 0;
   int unsigned frames_accepted = 0;
   int unsigned pairs_checked   = 0;
   int unsigned settings_run    = 0;
   int unsigned error_count     = 0;

   logic        offering     = 1'b0;   // a request is on the port, not yet taken
   logic        req_taken    = 1'b0;   // the last rising edge took a request
   bit          sender_idles = 1'b0;   // insert random gaps between requests
   int unsigned gap_left     = 0;
   rsp_type     pcm_want;

   task automatic report_mismatch(string what);
      // Count every failure, print only the first few dozen
      if (error_count < 40)
         $display("MISMATCH @%0t: %s", $time, what);
      error_count++;
   endtask

   // Round half away from zero of mag * 32767 / 2^sh, clamped to full scale
   function automatic logic [15:0] scale_by_full_scale(logic [52:0] mag, int unsigned sh);
      logic [68:0] prod;
      logic [68:0] quot;
      logic [68:0] rnd;
      if (mag == '0 || sh == 0 || sh - 1 > SHIFT_MAX)
         return '0;
      prod = 69'(mag) * 69'(FULL_SCALE);
      // Keep one fraction bit, then add half and drop it
      quot = prod >> (sh - 1);
      rnd  = (quot + 69'd1) >> 1;
      return (rnd > 69'd32767) ? 16'd32767 : rnd[15:0];
   endfunction

   // Convert one raw container word to signed PCM16 under the given settings
   function automatic logic signed [15:0] pcm16_of_raw(logic [63:0] raw, cfg_type c);
      logic [52:0]  mag;
      logic [63:0]  v;
      logic [7:0]   e8;
      logic [10:0]  e11;
      logic [15:0]  amp;
      int unsigned  sh;
      int unsigned  w;
      logic         neg;
      logic         sat;
      logic         nul;
      mag = '0;
      sh  = 0;
      neg = 1'b0;
      sat = 1'b0;
      nul = 1'b0;
      if (c.sample_format == FMT_FLOAT) begin
         if (c.container_bytes == BYTES_4) begin
            neg = raw[31];
            e8  = raw[30:23];
            if (e8 == 8'hFF && raw[22:0] != '0)
               nul = 1'b1;                        // NaN
            else if (e8 >= 8'd127)
               sat = 1'b1;                        // |x| >= 1 or infinity
            else if (e8 == 8'd0) begin
               mag = 53'(raw[22:0]);              // subnormal
               sh  = 149;
            end else begin
               mag = 53'({1'b1, raw[22:0]});
               sh  = 150 - e8;
            end
         end else if (c.container_bytes == BYTES_8) begin
            neg = raw[63];
            e11 = raw[62:52];
            if (e11 == 11'h7FF && raw[51:0] != '0)
               nul = 1'b1;
            else if (e11 >= 11'd1023)
               sat = 1'b1;
            else if (e11 == 11'd0) begin
               mag = 53'(raw[51:0]);
               sh  = 1074;
            end else begin
               mag = {1'b1, raw[51:0]};
               sh  = 1075 - e11;
            end
         end else begin
            nul = 1'b1;                           // float needs 4 or 8 bytes
         end
      end else if (c.container_bytes == BYTES_1) begin
         // Unsigned 8-bit: 0x80 is silence, offset binary around it
         neg = ~raw[7];
         mag = raw[7] ? 53'(raw[6:0]) : 53'(9'd128 - {1'b0, raw[7:0]});
         sh  = 7;
      end else if (c.container_bytes >= BYTES_2 && c.container_bytes <= BYTES_4) begin
         w   = 8 * c.container_bytes;
         v   = raw & ((64'd1 << w) - 64'd1);
         neg = v[w-1];
         mag = neg ? 53'((64'd1 << w) - v) : 53'(v);
         sh  = w - 1;
      end else begin
         nul = 1'b1;                              // unsupported integer width
      end
      amp = sat ? 16'd32767 : scale_by_full_scale(mag, sh);
      if (nul)
         return '0;
      return neg ? -$signed(amp) : $signed(amp);
   endfunction

   function automatic rsp_type convert_frame(req_type r, cfg_type c);
      rsp_type pair;
      pair.left_pcm  = pcm16_of_raw(r.left_raw, c);
      // Mono input: copy left into right
      pair.right_pcm = c.stereo_input ? pcm16_of_raw(r.right_raw, c) : pair.left_pcm;
      pair.last_out  = r.last_in_packet;
      return pair;
   endfunction

   // Interesting container words across all formats
   function automatic logic [63:0] corner_word(int unsigned k);
      case (k)
         0:       return 64'h0000_0000_0000_0000;
         1:       return 64'hFFFF_FFFF_FFFF_FFFF;
         2:       return 64'h8000_0000_0000_0000;   // negative zero, double
         3:       return 64'h7FFF_FFFF_FFFF_FFFF;   // NaN, double
         4:       return 64'h0000_0000_8000_0000;   // full-scale negative int32
         5:       return 64'h0000_0000_7FFF_FFFF;
         6:       return 64'h0000_0000_0000_0080;   // 8-bit silence
         7:       return 64'h0000_0000_0000_007F;
         8:       return 64'h0000_0000_0000_8000;   // full-scale negative int16
         9:       return 64'h0000_0000_0000_7FFF;
         10:      return 64'h0000_0000_0080_0000;
         11:      return 64'h0000_0000_007F_FFFF;
         12:      return 64'h0000_0000_3F80_0000;   // 1.0 single
         13:      return 64'h0000_0000_BF00_0000;   // -0.5 single
         14:      return 64'h0000_0000_7F80_0000;   // +inf single
         15:      return 64'h0000_0000_FF80_0000;   // -inf single
         16:      return 64'h0000_0000_7FC0_0000;   // NaN single
         17:      return 64'h0000_0000_0000_0001;   // smallest subnormal
         18:      return 64'h3FF0_0000_0000_0000;   // 1.0 double
         19:      return 64'hFFF0_0000_0000_0000;   // -inf double
         20:      return 64'h7FF8_0000_0000_0000;
         21:      return 64'h0000_0000_3F7F_FFFF;   // just under 1.0 single
         22:      return 64'h3FEF_FFFF_FFFF_FFFF;   // just under 1.0 double
         23:      return 64'h0000_0000_0000_4000;   // int16 lands exactly on a half
         default: return 64'h0000_0000_0000_C000;
      endcase
   endfunction

   // Random container word, biased towards corners and in-range float exponents
   function automatic logic [63:0] pick_raw(cfg_type c);
      logic [63:0] raw;
      int unsigned pick;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 3)
         raw = corner_word($urandom_range(0, CORNER_COUNT - 1));
      else if (pick < 8 && c.sample_format == FMT_FLOAT) begin
         if (c.container_bytes == BYTES_8)
            raw[62:52] = 11'($urandom_range(990, 1024));
         else
            raw[30:23] = 8'($urandom_range(105, 128));
      end
      return raw;
   endfunction

   task automatic queue_frame(logic [63:0] left, logic [63:0] right, logic last);
      frame_backlog.push_back('{left_raw: left, right_raw: right, last_in_packet: last});
      frames_queued++;
   endtask

   // Setup then access; the register lands at the edge that sees pready
   task automatic csr_write(logic [3:0] addr, logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (addr[3:2])
         REG_SAMPLE_FORMAT:   model_cfg.sample_format   = data[0];
         REG_CONTAINER_BYTES: model_cfg.container_bytes = data[3:0];
         REG_STEREO_INPUT:    model_cfg.stereo_input    = data[0];
         default: ;   // no register here: drop the write
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Hold until every request is taken and every pair has come back
   task automatic drain_results();
      int unsigned waited;
      while (frames_accepted != frames_queued)
         @(posedge clock);
      waited = 0;
      while (pcm_expected.size() != 0 && waited < 64) begin
         @(posedge clock);
         waited++;
      end
      if (pcm_expected.size() != 0) begin
         report_mismatch($sformatf("%0d stereo pairs never arrived", pcm_expected.size()));
         pcm_expected.delete();
      end
      // Let the pipeline settle before touching the registers
      repeat (6) @(posedge clock);
   endtask

   // Reprogram all registers with junk in the unused bits, then queue random frames
   task automatic run_phase(logic fmt, logic [3:0] nbytes, logic stereo,
                            int unsigned count, bit idles);
      cfg_type c;
      c = '{sample_format: fmt, container_bytes: nbytes, stereo_input: stereo};
      drain_results();
      csr_write({REG_SAMPLE_FORMAT, 2'b00}, ($urandom & ~32'd1) | 32'(fmt));
      csr_write({REG_CONTAINER_BYTES, 2'b00}, ($urandom & ~32'hF) | 32'(nbytes));
      csr_write({REG_STEREO_INPUT, 2'b00}, ($urandom & ~32'd1) | 32'(stereo));
      csr_write({REG_UNUSED, 2'b00}, $urandom);
      sender_idles = idles;
      settings_run++;
      repeat (count)
         queue_frame(pick_raw(c), pick_raw(c), $urandom_range(0, 7) == 0);
   endtask

   // Driver: offer the next request on the falling edge, hold it until taken
   always @(negedge clock) begin
      if (reset) begin
         offering = 1'b0;
         start    <= 1'b0;
      end else begin
         if (offering && req_taken)
            offering = 1'b0;
         if (!offering) begin
            if (gap_left != 0)
               gap_left--;
            else if (frame_backlog.size() != 0) begin
               req_data <= frame_backlog.pop_front();
               offering = 1'b1;
               gap_left = sender_idles ? $urandom_range(0, 8) : 0;
            end
         end
         start <= offering;
      end
   end

   // Monitor: predict on each accepted request, check each strobed result
   always @(posedge clock) begin
      req_taken = !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            if (pcm_expected.size() == 0)
               report_mismatch("stereo pair with no request outstanding");
            else begin
               pcm_want = pcm_expected.pop_front();
               if (rsp_data.left_pcm !== pcm_want.left_pcm)
                  report_mismatch($sformatf("left_pcm %0d, want %0d",
                                            rsp_data.left_pcm, pcm_want.left_pcm));
               if (rsp_data.right_pcm !== pcm_want.right_pcm)
                  report_mismatch($sformatf("right_pcm %0d, want %0d",
                                            rsp_data.right_pcm, pcm_want.right_pcm));
               if (rsp_data.last_out !== pcm_want.last_out)
                  report_mismatch($sformatf("last_out %b, want %b",
                                            rsp_data.last_out, pcm_want.last_out));
               pairs_checked++;
            end
         end
         if (req_taken) begin
            pcm_expected.push_back(convert_frame(req_data, model_cfg));
            frames_accepted++;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corner words under the reset settings (signed 16-bit, stereo), back to back
      for (int unsigned k = 0; k < CORNER_COUNT; k++)
         queue_frame(corner_word(k), corner_word((k + 7) % CORNER_COUNT), k[0]);

      // Walk the settings: every width and format, mono and stereo, unsupported sizes
      run_phase(FMT_INTEGER, BYTES_1, 1'b1, 110, 1'b1);
      run_phase(FMT_INTEGER, BYTES_2, 1'b0, 100, 1'b0);
      run_phase(FMT_INTEGER, BYTES_3, 1'b1, 110, 1'b1);
      run_phase(FMT_INTEGER, BYTES_4, 1'b1, 110, 1'b1);
      run_phase(FMT_FLOAT,   BYTES_4, 1'b1, 150, 1'b1);
      run_phase(FMT_FLOAT,   BYTES_8, 1'b1, 150, 1'b0);
      run_phase(FMT_INTEGER, 4'd0,    1'b1,  30, 1'b1);
      run_phase(FMT_FLOAT,   BYTES_4, 1'b0, 110, 1'b1);
      run_phase(FMT_FLOAT,   BYTES_8, 1'b0, 110, 1'b1);
      run_phase(FMT_FLOAT,   BYTES_2, 1'b1,  30, 1'b0);
      run_phase(FMT_INTEGER, 4'd15,   1'b0,  30, 1'b1);
      run_phase(FMT_FLOAT,   4'd15,   1'b1,  30, 1'b1);
      run_phase(FMT_INTEGER, 4'd5,    1'b1,  30, 1'b0);
      run_phase(FMT_INTEGER, BYTES_1, 1'b0, 100, 1'b1);
      run_phase(FMT_INTEGER, BYTES_4, 1'b0, 100, 1'b1);
      run_phase(FMT_INTEGER, BYTES_2, 1'b1, 150, 1'b1);
      run_phase(FMT_FLOAT,   BYTES_8, 1'b1,  60, 1'b1);
      drain_results();

      $display("Checked %0d stereo pairs from %0d frames over %0d register settings.",
               pairs_checked, frames_accepted, settings_run + 1);
      $display("Covered u8, s16/s24/s32, float32/64, unsupported sizes, mono and stereo.");
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("Run timed out with %0d frames outstanding", frames_queued - frames_accepted);
      $display("Verification failed");
      $finish;
   end

endmodule
